>>> src/ubrr_pkg.sv
package ubrr_pkg;

    localparam int WORD_W  = 64;
    localparam int VALUE_W = 63;
    localparam int NSTEP   = WORD_W;

    localparam logic [WORD_W-1:0] BOUND_RESET = WORD_W'(1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_BAD_BOUND = 2'd2
    } t_status;

endpackage

>>> src/ubrr_word_if.sv
interface ubrr_word_if;

    logic                        valid;
    logic                        ready;
    logic [ubrr_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);

endinterface

>>> src/ubrr_result_if.sv
interface ubrr_result_if;

    logic                         valid;
    logic                         ready;
    ubrr_pkg::t_status            status;
    logic [ubrr_pkg::VALUE_W-1:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);

endinterface

>>> src/unbiased_bounded_random_reducer.sv
// Unbiased bounded random reducer.
// i_word carries raw 64-bit random words (valid/ready); o_result returns one
// word per input: status OK with word mod bound, REJECT when the word falls in
// the partial low bucket (supply another word), or BAD_BOUND when the bound
// is zero or negative. Rejected and bad-bound results carry value zero.
// i_bound_we/i_bound write the signed bound; write it only while idle.
// The remainder comes from a 64-stage restoring divider, one quotient bit
// per stage; one word enters per cycle unless the skid register is full or
// a threshold computation is pending or in flight. After a write of a valid
// bound, the same divider computes the reject threshold (2^64 mod bound):
// i_word.ready stays low until it lands. A non-positive bound acts at once.
// Reset (synchronous, active low) sets bound to one, threshold to zero and
// empties the pipeline. When the receiver stalls, a skid register takes one
// more result, then the whole pipeline holds; nothing is dropped or repeated.
module unbiased_bounded_random_reducer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ubrr_word_if.sink                           i_word,
    ubrr_result_if.source                       o_result,
    input  logic                                i_bound_we,
    input  logic signed [ubrr_pkg::WORD_W-1:0]  i_bound
);

    localparam int W  = ubrr_pkg::WORD_W;
    localparam int VW = ubrr_pkg::VALUE_W;
    localparam int NS = ubrr_pkg::NSTEP;

    logic [W-1:0] r_bound;
    logic [W-1:0] r_threshold;
    logic         r_thr_pend;
    logic         r_thr_busy;

    // pipeline stage 0 is the entry register, stage NS holds the remainder
    logic              r_valid [0:NS];
    logic              r_thr   [0:NS];
    ubrr_pkg::t_status r_stat  [0:NS];
    logic [VW-1:0]     r_rem   [0:NS];
    logic [W-1:0]      r_q     [0:NS];

    logic [VW-1:0]     n_rem   [1:NS];

    logic              r_ov;
    ubrr_pkg::t_status r_ostat;
    logic [VW-1:0]     r_oval;
    logic              r_sv;
    ubrr_pkg::t_status r_sstat;
    logic [VW-1:0]     r_sval;

    logic              bound_ok;
    logic              en;
    logic              accept;
    logic              inject;
    logic              take;
    logic              res_v;
    logic              thr_done;
    ubrr_pkg::t_status n_stat0;
    logic [VW-1:0]     res_val;

    assign bound_ok = (r_bound != '0) && !r_bound[W-1];
    assign en       = !r_sv;
    assign i_word.ready = en && !r_thr_pend && !r_thr_busy;
    assign accept   = i_word.valid && i_word.ready;
    assign inject   = en && r_thr_pend;
    assign take     = r_ov && o_result.ready;
    assign res_v    = en && r_valid[NS] && !r_thr[NS];
    assign thr_done = en && r_valid[NS] && r_thr[NS];
    assign res_val  = (r_stat[NS] == ubrr_pkg::ST_OK) ? r_rem[NS] : '0;

    assign o_result.valid  = r_ov;
    assign o_result.status = r_ostat;
    assign o_result.value  = r_oval;

    always_comb begin
        if (!bound_ok) begin
            n_stat0 = ubrr_pkg::ST_BAD_BOUND;
        end else if (i_word.random_word < r_threshold) begin
            n_stat0 = ubrr_pkg::ST_REJECT;
        end else begin
            n_stat0 = ubrr_pkg::ST_OK;
        end
    end

    // one restoring division step per stage
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            logic [W-1:0] t;
            logic [W-1:0] d;
            t = {r_rem[s], r_q[s][W-1]};
            d = {1'b0, r_bound[VW-1:0]};
            if (t >= d) begin
                n_rem[s+1] = VW'(t - d);
            end else begin
                n_rem[s+1] = t[VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_thr[0]  <= inject;
            r_stat[0] <= n_stat0;
            r_rem[0]  <= '0;
            r_q[0]    <= inject ? (W'(0) - r_bound) : i_word.random_word;
            for (int s = 1; s <= NS; s++) begin
                r_thr[s]  <= r_thr[s-1];
                r_stat[s] <= r_stat[s-1];
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= {r_q[s-1][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (en) begin
            r_valid[0] <= accept || inject;
            for (int s = 1; s <= NS; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound     <= ubrr_pkg::BOUND_RESET;
            r_threshold <= '0;
            r_thr_pend  <= 1'b0;
            r_thr_busy  <= 1'b0;
        end else begin
            if (inject) begin
                r_thr_pend <= 1'b0;
                r_thr_busy <= 1'b1;
            end
            if (thr_done) begin
                r_thr_busy  <= 1'b0;
                r_threshold <= W'(r_rem[NS]);
            end
            if (i_bound_we) begin
                r_bound <= i_bound;
                if ((i_bound != '0) && !i_bound[W-1]) begin
                    r_thr_pend <= 1'b1;
                end else begin
                    r_threshold <= '0;
                end
            end
        end
    end

    // output register plus skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || take) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= res_v;
            end
        end else if (res_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || take) begin
            if (r_sv) begin
                r_ostat <= r_sstat;
                r_oval  <= r_sval;
            end else begin
                r_ostat <= r_stat[NS];
                r_oval  <= res_val;
            end
        end else if (res_v) begin
            r_sstat <= r_stat[NS];
            r_sval  <= res_val;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WORD_W       = ubrr_pkg::WORD_W;
    localparam int VALUE_W      = ubrr_pkg::VALUE_W;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 158;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        ubrr_pkg::t_status  status;
        logic [VALUE_W-1:0] value;
    } t_draw;

    typedef struct packed {
        logic               set_bound;
        logic [WORD_W-1:0]  bound;
        logic [WORD_W-1:0]  word;
        logic               typed;
        ubrr_pkg::t_status  status;
        logic [VALUE_W-1:0] value;
    } t_dir_row;

    localparam int DIR_ROWS = 21;

    // Rows with typed = 0 are checked against the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{1'b0, 64'd1, 64'd0, 1'b1, ubrr_pkg::ST_OK, 63'd0},
        '{1'b0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ubrr_pkg::ST_OK, 63'd0},
        '{1'b1, 64'd0, 64'h1234_5678_9ABC_DEF0, 1'b1, ubrr_pkg::ST_BAD_BOUND, 63'd0},
        '{1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ubrr_pkg::ST_BAD_BOUND, 63'd0},
        '{1'b1, 64'h8000_0000_0000_0000, 64'd0, 1'b1, ubrr_pkg::ST_BAD_BOUND, 63'd0},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 1'b1, ubrr_pkg::ST_BAD_BOUND, 63'd0},
        '{1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, ubrr_pkg::ST_REJECT, 63'd0},
        '{1'b0, 64'd0, 64'd1, 1'b1, ubrr_pkg::ST_REJECT, 63'd0},
        '{1'b0, 64'd0, 64'd2, 1'b1, ubrr_pkg::ST_OK, 63'd2},
        '{1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ubrr_pkg::ST_OK, 63'd1},
        '{1'b0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ubrr_pkg::ST_OK, 63'd0},
        '{1'b0, 64'd0, 64'h8000_0000_0000_0000, 1'b1, ubrr_pkg::ST_OK, 63'd1},
        '{1'b1, 64'd3, 64'd0, 1'b1, ubrr_pkg::ST_REJECT, 63'd0},
        '{1'b0, 64'd0, 64'd1, 1'b1, ubrr_pkg::ST_OK, 63'd1},
        '{1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ubrr_pkg::ST_OK, 63'd0},
        '{1'b1, 64'h4000_0000_0000_0001, 64'h3FFF_FFFF_FFFF_FFFC, 1'b1,
          ubrr_pkg::ST_REJECT, 63'd0},
        '{1'b0, 64'd0, 64'h3FFF_FFFF_FFFF_FFFD, 1'b0, ubrr_pkg::ST_OK, 63'd0},
        '{1'b0, 64'd0, 64'hDEAD_BEEF_0123_4567, 1'b0, ubrr_pkg::ST_OK, 63'd0},
        '{1'b1, 64'd2, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, ubrr_pkg::ST_OK, 63'd0},
        '{1'b1, 64'd1000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ubrr_pkg::ST_OK, 63'd0},
        '{1'b1, 64'd1, 64'd42, 1'b1, ubrr_pkg::ST_OK, 63'd0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_bound_we;
    logic [WORD_W-1:0] i_bound;

    ubrr_word_if   word_if ();
    ubrr_result_if res_if ();

    unbiased_bounded_random_reducer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (word_if),
        .o_result   (res_if),
        .i_bound_we (i_bound_we),
        .i_bound    (i_bound)
    );

    always #5 i_clk = ~i_clk;

    logic [WORD_W-1:0] bound_pred  = 64'd1;
    logic [WORD_W-1:0] floor_pred  = 64'd0;
    t_draw             pending_draws [$];
    int                mismatches  = 0;
    int                idle_cycles = 0;
    logic              typed_now   = 1'b0;
    t_draw             typed_draw;
    int                gap_pct     = 0;
    int                stall_pct   = 0;
    logic              steady      = 1'b0;
    int                stall_left  = 0;
    logic              stall_on    = 1'b0;

    function automatic logic bound_ok(logic [WORD_W-1:0] b);
        return b != '0 && !b[WORD_W-1];
    endfunction

    // 2^64 mod bound, the size of the partial low bucket
    function automatic logic [WORD_W-1:0] reject_floor_of(logic [WORD_W-1:0] b);
        if (!bound_ok(b))
            return '0;
        return (~b + 64'd1) % b;
    endfunction

    function automatic t_draw reduce_word(logic [WORD_W-1:0] w);
        t_draw d;
        d.status = ubrr_pkg::ST_OK;
        d.value  = '0;
        if (!bound_ok(bound_pred))
            d.status = ubrr_pkg::ST_BAD_BOUND;
        else if (w < floor_pred)
            d.status = ubrr_pkg::ST_REJECT;
        else
            d.value = VALUE_W'(w % bound_pred);
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_draw  want;
        logic   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_bound_we) begin
                bound_pred = i_bound;
                floor_pred = reject_floor_of(i_bound);
                moved = 1'b1;
            end
            if (word_if.valid && word_if.ready) begin
                pending_draws.push_back(typed_now ? typed_draw
                                                  : reduce_word(word_if.random_word));
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                if (pending_draws.size() == 0) begin
                    report_mismatch("unexpected result", WORD_W'(res_if.value), '0);
                end else begin
                    want = pending_draws.pop_front();
                    if (res_if.status !== want.status)
                        report_mismatch("status", WORD_W'(res_if.status),
                                        WORD_W'(want.status));
                    if (res_if.value !== want.value)
                        report_mismatch("value", WORD_W'(res_if.value),
                                        WORD_W'(want.value));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, none when steady
    always @(negedge i_clk) begin
        if (steady) begin
            res_if.ready <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(1, 18);
                stall_on   = $urandom_range(0, 99) < stall_pct;
            end
            stall_left--;
            res_if.ready <= !stall_on;
        end
    end

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_word(logic [WORD_W-1:0] w, logic typed, t_draw d);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            word_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_now  = typed;
        typed_draw = d;
        word_if.valid       <= 1'b1;
        word_if.random_word <= w;
        @(posedge i_clk);
        while (!word_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected result is back.
    task automatic wait_drain();
        word_if.valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_bound(logic [WORD_W-1:0] b);
        wait_drain();
        i_bound_we <= 1'b1;
        i_bound    <= b;
        @(negedge i_clk);
        i_bound_we <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return floor_pred + 64'($urandom_range(0, 2)) - 64'd1;
            3: return bound_pred * 64'($urandom_range(0, 7)) + 64'($urandom_range(0, 2));
            4: return 64'($urandom_range(0, 4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] phase_bound(int p);
        case (p)
            0:  return 64'd3;
            1:  return 64'h7FFF_FFFF_FFFF_FFFF;
            2:  return 64'h4000_0000_0000_0001;
            3:  return 64'($urandom_range(1, 1000));
            4:  return 64'h8000_0000_0000_0000;
            5:  return {1'b0, 31'($urandom), $urandom} | 64'd1;
            6:  return 64'd0;
            7:  return 64'd1 << $urandom_range(0, 62);
            8:  return {1'b1, 31'($urandom), $urandom};
            9:  return 64'h8000_0000_0000_0000 - 64'($urandom_range(1, 1000));
            10: return 64'd2;
            default: return 64'($urandom_range(1, 16));
        endcase
    endfunction

    initial begin
        t_draw none;
        none.status = ubrr_pkg::ST_OK;
        none.value  = '0;
        i_rst_n             = 1'b0;
        i_bound_we          = 1'b0;
        i_bound             = 64'd1;
        word_if.valid       = 1'b0;
        word_if.random_word = '0;
        res_if.ready        = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct   = 30;
        stall_pct = 30;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].set_bound)
                write_bound(dir_rows[r].bound);
            send_word(dir_rows[r].word, dir_rows[r].typed,
                      t_draw'{dir_rows[r].status, dir_rows[r].value});
        end

        for (int p = 0; p < PHASES; p++) begin
            write_bound(phase_bound(p));
            gap_pct   = (p % 3 == 2) ? 0 : $urandom_range(10, 50);
            stall_pct = (p % 4 == 3) ? 0 : $urandom_range(10, 50);
            if (p == PHASES - 1) begin
                gap_pct = 0;
                steady  = 1'b1;
            end
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 5 && i == PHASE_WORDS / 2)
                    wait_drain();
                send_word(pick_word(), 1'b0, none);
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_draws.size() != 0)
            report_mismatch("results missing", 64'(pending_draws.size()), '0);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/ubrr_pkg.sv
src/ubrr_word_if.sv
src/ubrr_result_if.sv
src/unbiased_bounded_random_reducer.sv
tb/tb_top.sv
